>>> sv/text_value_tokenizer_defines.svh
// assertion macros shared by the tokenizer modules
// no dependencies; taken in by `include where checks are written
`ifndef TEXT_VALUE_TOKENIZER_DEFINES_SVH
`define TEXT_VALUE_TOKENIZER_DEFINES_SVH

// property checked on every clock edge outside reset
`define TVT_ASSERT(label, clk, rstn, prop) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("assertion failed in %m");

// same-cycle implication outside reset
`define TVT_ASSERT_IMPL(label, clk, rstn, a, b) \
    label: assert property (@(posedge clk) disable iff (!rstn) (a) |-> (b)) \
        else $error("assertion failed in %m");

`endif

>>> sv/tvt_pkg.sv
// shared types and codes for the text value tokenizer
// no dependencies; used by every tokenizer module
package tvt_pkg;

    localparam logic [3:0] TOK_CURLY_OPEN  = 4'd0;
    localparam logic [3:0] TOK_CURLY_CLOSE = 4'd1;
    localparam logic [3:0] TOK_BRACK_OPEN  = 4'd2;
    localparam logic [3:0] TOK_BRACK_CLOSE = 4'd3;
    localparam logic [3:0] TOK_PAREN_OPEN  = 4'd4;
    localparam logic [3:0] TOK_PAREN_CLOSE = 4'd5;
    localparam logic [3:0] TOK_IDENT       = 4'd6;
    localparam logic [3:0] TOK_STRING      = 4'd7;
    localparam logic [3:0] TOK_NUMBER      = 4'd8;
    localparam logic [3:0] TOK_COLON       = 4'd9;
    localparam logic [3:0] TOK_COMMA       = 4'd10;
    localparam logic [3:0] TOK_EQUAL       = 4'd11;
    localparam logic [3:0] TOK_EOF         = 4'd12;
    localparam logic [3:0] TOK_ERROR       = 4'd13;

    localparam logic [1:0] ERR_NONE       = 2'd0;
    localparam logic [1:0] ERR_UNTERM_STR = 2'd1;
    localparam logic [1:0] ERR_BAD_HEX    = 2'd2;
    localparam logic [1:0] ERR_UNEXPECTED = 2'd3;

    localparam logic EV_CONTENT  = 1'b0;
    localparam logic EV_COMPLETE = 1'b1;

    typedef struct packed {
        logic        event_res;
        logic [3:0]  token_type;
        logic [15:0] char_value;
        logic        frac_flag;
        logic [1:0]  error_code;
    } res_t;

    // results caused by one input byte
    typedef struct packed {
        logic        two_res;
        res_t        res0;
        res_t        res1;
        logic [31:0] line_number;
    } entry_t;

    function automatic res_t make_res(input logic ev, input logic [3:0] tok,
                                      input logic [15:0] val, input logic fl,
                                      input logic [1:0] err);
        res_t r;
        r.event_res  = ev;
        r.token_type = tok;
        r.char_value = val;
        r.frac_flag  = fl;
        r.error_code = err;
        return r;
    endfunction

endpackage

>>> sv/tvt_front.sv
// lexer front end: accepts bytes, runs the token state machine, emits entries
// depends on tvt_pkg
module tvt_front (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [7:0]        s_tdata,   // char_in[7:0]
    input  logic              q_full,
    output logic              q_push,
    output tvt_pkg::entry_t   q_entry
);

    typedef enum logic [2:0] {
        MODE_IDLE, MODE_STR, MODE_ESC, MODE_HEX, MODE_INT, MODE_DEC, MODE_EXP, MODE_ID
    } mode_t;

    typedef struct packed {
        logic          has;
        tvt_pkg::res_t res;
        mode_t         mode;
        logic          num_init;
        logic          bump;
    } start_t;

    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_NL     = 8'h0a;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_PLUS   = 8'h2b;
    localparam logic [7:0] CH_COMMA  = 8'h2c;
    localparam logic [7:0] CH_MINUS  = 8'h2d;
    localparam logic [7:0] CH_DOT    = 8'h2e;
    localparam logic [7:0] CH_COLON  = 8'h3a;
    localparam logic [7:0] CH_EQUAL  = 8'h3d;
    localparam logic [7:0] CH_LBRACK = 8'h5b;
    localparam logic [7:0] CH_BSLASH = 8'h5c;
    localparam logic [7:0] CH_RBRACK = 8'h5d;
    localparam logic [7:0] CH_LCURLY = 8'h7b;
    localparam logic [7:0] CH_RCURLY = 8'h7d;
    localparam logic [7:0] CH_LOW_B  = 8'h62;
    localparam logic [7:0] CH_LOW_E  = 8'h65;
    localparam logic [7:0] CH_LOW_F  = 8'h66;
    localparam logic [7:0] CH_LOW_N  = 8'h6e;
    localparam logic [7:0] CH_LOW_R  = 8'h72;
    localparam logic [7:0] CH_LOW_T  = 8'h74;
    localparam logic [7:0] CH_LOW_U  = 8'h75;

    localparam logic [15:0] VAL_BS = 16'd8;
    localparam logic [15:0] VAL_HT = 16'd9;
    localparam logic [15:0] VAL_LF = 16'd10;
    localparam logic [15:0] VAL_FF = 16'd12;
    localparam logic [15:0] VAL_CR = 16'd13;

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= 8'h30) && (c <= 8'h39);
    endfunction

    function automatic logic is_alpha(input logic [7:0] c);
        return ((c >= 8'h41) && (c <= 8'h5a)) || ((c >= 8'h61) && (c <= 8'h7a))
            || (c == 8'h5f);
    endfunction

    // {valid, digit value}
    function automatic logic [4:0] hex_val(input logic [7:0] c);
        logic [4:0] h;
        h = 5'd0;
        if (is_digit(c)) begin
            h = {1'b1, c[3:0]};
        end else if (((c >= 8'h41) && (c <= 8'h46)) || ((c >= 8'h61) && (c <= 8'h66))) begin
            h = {1'b1, c[3:0] + 4'd9};
        end
        return h;
    endfunction

    function automatic start_t token_start(input logic [7:0] c);
        start_t st;
        st.has      = 1'b0;
        st.res      = '0;
        st.mode     = MODE_IDLE;
        st.num_init = 1'b0;
        st.bump     = 1'b0;
        unique case (c)
            CH_LCURLY: begin st.has = 1'b1; st.res = tvt_pkg::make_res(
                tvt_pkg::EV_COMPLETE, tvt_pkg::TOK_CURLY_OPEN, 16'd0, 1'b0, tvt_pkg::ERR_NONE);
            end
            CH_RCURLY: begin st.has = 1'b1; st.res = tvt_pkg::make_res(
                tvt_pkg::EV_COMPLETE, tvt_pkg::TOK_CURLY_CLOSE, 16'd0, 1'b0, tvt_pkg::ERR_NONE);
            end
            CH_LBRACK: begin st.has = 1'b1; st.res = tvt_pkg::make_res(
                tvt_pkg::EV_COMPLETE, tvt_pkg::TOK_BRACK_OPEN, 16'd0, 1'b0, tvt_pkg::ERR_NONE);
            end
            CH_RBRACK: begin st.has = 1'b1; st.res = tvt_pkg::make_res(
                tvt_pkg::EV_COMPLETE, tvt_pkg::TOK_BRACK_CLOSE, 16'd0, 1'b0, tvt_pkg::ERR_NONE);
            end
            CH_LPAREN: begin st.has = 1'b1; st.res = tvt_pkg::make_res(
                tvt_pkg::EV_COMPLETE, tvt_pkg::TOK_PAREN_OPEN, 16'd0, 1'b0, tvt_pkg::ERR_NONE);
            end
            CH_RPAREN: begin st.has = 1'b1; st.res = tvt_pkg::make_res(
                tvt_pkg::EV_COMPLETE, tvt_pkg::TOK_PAREN_CLOSE, 16'd0, 1'b0, tvt_pkg::ERR_NONE);
            end
            CH_COLON: begin st.has = 1'b1; st.res = tvt_pkg::make_res(
                tvt_pkg::EV_COMPLETE, tvt_pkg::TOK_COLON, 16'd0, 1'b0, tvt_pkg::ERR_NONE);
            end
            CH_COMMA: begin st.has = 1'b1; st.res = tvt_pkg::make_res(
                tvt_pkg::EV_COMPLETE, tvt_pkg::TOK_COMMA, 16'd0, 1'b0, tvt_pkg::ERR_NONE);
            end
            CH_EQUAL: begin st.has = 1'b1; st.res = tvt_pkg::make_res(
                tvt_pkg::EV_COMPLETE, tvt_pkg::TOK_EQUAL, 16'd0, 1'b0, tvt_pkg::ERR_NONE);
            end
            default: begin
                priority if (c == CH_NL) begin
                    st.bump = 1'b1;
                end else if (c == CH_NUL) begin
                    st.has = 1'b1;
                    st.res = tvt_pkg::make_res(tvt_pkg::EV_COMPLETE, tvt_pkg::TOK_EOF,
                                               16'd0, 1'b0, tvt_pkg::ERR_NONE);
                end else if (c == CH_QUOTE) begin
                    st.mode = MODE_STR;
                end else if (c <= CH_SPACE) begin
                    st.has = 1'b0;
                end else if ((c == CH_MINUS) || is_digit(c)) begin
                    st.has      = 1'b1;
                    st.num_init = 1'b1;
                    st.mode     = MODE_INT;
                    st.res      = tvt_pkg::make_res(tvt_pkg::EV_CONTENT, tvt_pkg::TOK_NUMBER,
                                                    {8'h00, c}, 1'b0, tvt_pkg::ERR_NONE);
                end else if (is_alpha(c)) begin
                    st.has  = 1'b1;
                    st.mode = MODE_ID;
                    st.res  = tvt_pkg::make_res(tvt_pkg::EV_CONTENT, tvt_pkg::TOK_IDENT,
                                                {8'h00, c}, 1'b0, tvt_pkg::ERR_NONE);
                end else begin
                    st.has = 1'b1;
                    st.res = tvt_pkg::make_res(tvt_pkg::EV_COMPLETE, tvt_pkg::TOK_ERROR,
                                               16'd0, 1'b0, tvt_pkg::ERR_UNEXPECTED);
                end
            end
        endcase
        return st;
    endfunction

    mode_t        mode_reg, mode_next;
    logic [1:0]   hex_cnt_reg, hex_cnt_next;
    logic [15:0]  hex_acc_reg, hex_acc_next;
    logic         exp_sign_reg, exp_sign_next;
    logic         exp_digit_reg, exp_digit_next;
    logic         frac_reg, frac_next;
    logic [31:0]  line_reg, line_next;

    logic [7:0]    c;
    logic          accept;
    start_t        st;
    logic [4:0]    hv;
    logic [15:0]   acc_shift;
    logic [15:0]   esc_val;
    logic [31:0]   line_inc;
    logic          do_start;
    logic          has0, has1;
    tvt_pkg::res_t r0, r1;

    assign c         = s_tdata;
    assign s_tready  = !q_full;
    assign accept    = s_tvalid && s_tready;
    assign st        = token_start(c);
    assign hv        = hex_val(c);
    assign acc_shift = {hex_acc_reg[11:0], hv[3:0]};
    assign line_inc  = (line_reg == 32'hffff_ffff) ? line_reg : line_reg + 32'd1;

    always_comb begin
        unique case (c)
            CH_LOW_B: esc_val = VAL_BS;
            CH_LOW_T: esc_val = VAL_HT;
            CH_LOW_N: esc_val = VAL_LF;
            CH_LOW_F: esc_val = VAL_FF;
            CH_LOW_R: esc_val = VAL_CR;
            default:  esc_val = {8'h00, c};
        endcase
    end

    always_comb begin
        mode_next      = mode_reg;
        hex_cnt_next   = hex_cnt_reg;
        hex_acc_next   = hex_acc_reg;
        exp_sign_next  = exp_sign_reg;
        exp_digit_next = exp_digit_reg;
        frac_next      = frac_reg;
        line_next      = line_reg;
        do_start       = 1'b0;
        has0           = 1'b0;
        has1           = 1'b0;
        r0             = '0;
        r1             = '0;

        unique case (mode_reg)
            MODE_STR: begin
                priority if (c == CH_NUL) begin
                    has0 = 1'b1;
                    r0 = tvt_pkg::make_res(tvt_pkg::EV_COMPLETE, tvt_pkg::TOK_ERROR,
                                           16'd0, 1'b0, tvt_pkg::ERR_UNTERM_STR);
                    mode_next = MODE_IDLE;
                end else if (c == CH_QUOTE) begin
                    has0 = 1'b1;
                    r0 = tvt_pkg::make_res(tvt_pkg::EV_COMPLETE, tvt_pkg::TOK_STRING,
                                           16'd0, 1'b0, tvt_pkg::ERR_NONE);
                    mode_next = MODE_IDLE;
                end else if (c == CH_BSLASH) begin
                    mode_next = MODE_ESC;
                end else begin
                    if (c == CH_NL) begin
                        line_next = line_inc;
                    end
                    has0 = 1'b1;
                    r0 = tvt_pkg::make_res(tvt_pkg::EV_CONTENT, tvt_pkg::TOK_STRING,
                                           {8'h00, c}, 1'b0, tvt_pkg::ERR_NONE);
                end
            end
            MODE_ESC: begin
                priority if (c == CH_NUL) begin
                    has0 = 1'b1;
                    r0 = tvt_pkg::make_res(tvt_pkg::EV_COMPLETE, tvt_pkg::TOK_ERROR,
                                           16'd0, 1'b0, tvt_pkg::ERR_UNTERM_STR);
                    mode_next = MODE_IDLE;
                end else if (c == CH_LOW_U) begin
                    hex_cnt_next = 2'd0;
                    hex_acc_next = 16'd0;
                    mode_next    = MODE_HEX;
                end else begin
                    has0 = 1'b1;
                    r0 = tvt_pkg::make_res(tvt_pkg::EV_CONTENT, tvt_pkg::TOK_STRING,
                                           esc_val, 1'b0, tvt_pkg::ERR_NONE);
                    mode_next = MODE_STR;
                end
            end
            MODE_HEX: begin
                priority if (c == CH_NUL) begin
                    has0 = 1'b1;
                    r0 = tvt_pkg::make_res(tvt_pkg::EV_COMPLETE, tvt_pkg::TOK_ERROR,
                                           16'd0, 1'b0, tvt_pkg::ERR_UNTERM_STR);
                    mode_next = MODE_IDLE;
                end else if (!hv[4]) begin
                    has0 = 1'b1;
                    r0 = tvt_pkg::make_res(tvt_pkg::EV_COMPLETE, tvt_pkg::TOK_ERROR,
                                           16'd0, 1'b0, tvt_pkg::ERR_BAD_HEX);
                    mode_next = MODE_IDLE;
                end else begin
                    hex_acc_next = acc_shift;
                    if (hex_cnt_reg == 2'd3) begin
                        has0 = 1'b1;
                        r0 = tvt_pkg::make_res(tvt_pkg::EV_CONTENT, tvt_pkg::TOK_STRING,
                                               acc_shift, 1'b0, tvt_pkg::ERR_NONE);
                        hex_cnt_next = 2'd0;
                        mode_next    = MODE_STR;
                    end else begin
                        hex_cnt_next = hex_cnt_reg + 2'd1;
                    end
                end
            end
            MODE_INT, MODE_DEC, MODE_EXP: begin
                priority if (is_digit(c)) begin
                    if (mode_reg == MODE_EXP) begin
                        exp_digit_next = 1'b1;
                    end
                    has0 = 1'b1;
                end else if ((c == CH_DOT) && (mode_reg == MODE_INT)) begin
                    frac_next = 1'b1;
                    mode_next = MODE_DEC;
                    has0 = 1'b1;
                end else if ((c == CH_LOW_E) && (mode_reg != MODE_EXP)) begin
                    mode_next = MODE_EXP;
                    has0 = 1'b1;
                end else if ((mode_reg == MODE_EXP) && ((c == CH_MINUS) || (c == CH_PLUS))
                             && !exp_sign_reg && !exp_digit_reg) begin
                    exp_sign_next = 1'b1;
                    has0 = 1'b1;
                end else begin
                    // number ends, byte is handled again as a token start
                    do_start = 1'b1;
                end
                if (do_start) begin
                    has0 = 1'b1;
                    r0 = tvt_pkg::make_res(tvt_pkg::EV_COMPLETE, tvt_pkg::TOK_NUMBER,
                                           16'd0, frac_reg, tvt_pkg::ERR_NONE);
                end else begin
                    r0 = tvt_pkg::make_res(tvt_pkg::EV_CONTENT, tvt_pkg::TOK_NUMBER,
                                           {8'h00, c}, 1'b0, tvt_pkg::ERR_NONE);
                end
            end
            MODE_ID: begin
                has0 = 1'b1;
                if (is_alpha(c)) begin
                    r0 = tvt_pkg::make_res(tvt_pkg::EV_CONTENT, tvt_pkg::TOK_IDENT,
                                           {8'h00, c}, 1'b0, tvt_pkg::ERR_NONE);
                end else begin
                    r0 = tvt_pkg::make_res(tvt_pkg::EV_COMPLETE, tvt_pkg::TOK_IDENT,
                                           16'd0, 1'b0, tvt_pkg::ERR_NONE);
                    do_start = 1'b1;
                end
            end
            default: begin
                do_start = 1'b1;
            end
        endcase

        if (do_start) begin
            mode_next = st.mode;
            if (st.bump) begin
                line_next = line_inc;
            end
            if (st.num_init) begin
                frac_next      = 1'b0;
                exp_sign_next  = 1'b0;
                exp_digit_next = 1'b0;
            end
            if (st.has) begin
                if (has0) begin
                    has1 = 1'b1;
                    r1   = st.res;
                end else begin
                    has0 = 1'b1;
                    r0   = st.res;
                end
            end
        end
    end

    // a line bump from a token start never precedes a result of the same byte
    assign q_push              = accept && has0;
    assign q_entry.two_res     = has1;
    assign q_entry.res0        = r0;
    assign q_entry.res1        = r1;
    assign q_entry.line_number = do_start ? line_reg : line_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg      <= MODE_IDLE;
            hex_cnt_reg   <= 2'd0;
            hex_acc_reg   <= 16'd0;
            exp_sign_reg  <= 1'b0;
            exp_digit_reg <= 1'b0;
            frac_reg      <= 1'b0;
            line_reg      <= 32'd1;
        end else if (accept) begin
            mode_reg      <= mode_next;
            hex_cnt_reg   <= hex_cnt_next;
            hex_acc_reg   <= hex_acc_next;
            exp_sign_reg  <= exp_sign_next;
            exp_digit_reg <= exp_digit_next;
            frac_reg      <= frac_next;
            line_reg      <= line_next;
        end
    end

endmodule

>>> sv/tvt_queue.sv
// short entry queue between the lexer front end and the output stage
// depends on tvt_pkg and text_value_tokenizer_defines.svh
`include "text_value_tokenizer_defines.svh"

module tvt_queue #(
    parameter int DEPTH = 4
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            push,
    input  tvt_pkg::entry_t push_entry,
    input  logic            pop,
    output tvt_pkg::entry_t pop_entry,
    output logic            full,
    output logic            nonempty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    tvt_pkg::entry_t  mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;

    assign full      = (count_reg == CNT_W'(DEPTH));
    assign nonempty  = (count_reg != '0);
    assign pop_entry = mem_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    `TVT_ASSERT(a_count_bound, aclk, aresetn, count_reg <= CNT_W'(DEPTH))
    `TVT_ASSERT_IMPL(a_no_push_full, aclk, aresetn, full, !push)
    `TVT_ASSERT_IMPL(a_no_pop_empty, aclk, aresetn, pop, nonempty)
    `TVT_ASSERT(a_count_up, aclk, aresetn, push && !pop |=> count_reg == $past(count_reg) + 1'b1)

endmodule

>>> sv/tvt_back.sv
// output stage: takes entries from the queue and sends one result per transfer
// depends on tvt_pkg and text_value_tokenizer_defines.svh
`include "text_value_tokenizer_defines.svh"

module tvt_back (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            q_nonempty,
    input  tvt_pkg::entry_t q_entry,
    output logic            q_pop,
    output logic            m_tvalid,
    input  logic            m_tready,
    output logic [55:0]     m_tdata,   // char_value[15:0], frac_flag, error_code[1:0],
                                       // line_number[31:0], zero fill
    output logic [4:0]      m_tuser,   // event_res, token_type[3:0]
    output logic            m_tlast
);

    tvt_pkg::entry_t cur_reg;
    logic            valid_reg;
    logic            phase_reg;   // high while the second result is shown
    logic            last_now;
    tvt_pkg::res_t   res;

    assign last_now = !cur_reg.two_res || phase_reg;
    assign q_pop    = q_nonempty && (!valid_reg || (m_tready && last_now));
    assign res      = phase_reg ? cur_reg.res1 : cur_reg.res0;

    assign m_tvalid = valid_reg;
    assign m_tlast  = last_now;
    assign m_tuser  = {res.token_type, res.event_res};
    assign m_tdata  = {5'd0, cur_reg.line_number, res.error_code, res.frac_flag,
                       res.char_value};

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            cur_reg <= q_entry;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            phase_reg <= 1'b0;
        end else if (q_pop) begin
            valid_reg <= 1'b1;
            phase_reg <= 1'b0;
        end else if (valid_reg && m_tready) begin
            if (!last_now) begin
                phase_reg <= 1'b1;
            end else begin
                valid_reg <= 1'b0;
                phase_reg <= 1'b0;
            end
        end
    end

    `TVT_ASSERT_IMPL(a_phase_pair, aclk, aresetn, phase_reg, valid_reg && cur_reg.two_res)
    `TVT_ASSERT_IMPL(a_pop_free, aclk, aresetn, q_pop, !valid_reg || (m_tready && last_now))
    `TVT_ASSERT(a_load, aclk, aresetn, !valid_reg && q_nonempty |=> valid_reg)

endmodule

>>> sv/text_value_tokenizer.sv
// text value tokenizer top level: byte stream in, token result stream out
// depends on tvt_pkg, tvt_front, tvt_queue and tvt_back
//
// usage:
//   s_tvalid/s_tready/s_tdata carry one input byte per transfer; byte 0 marks
//   end of input. m_tvalid/m_tready/m_tdata/m_tuser/m_tlast carry one token
//   result per transfer; m_tlast marks the last result caused by a byte.
//   a byte may cause zero, one or two results.
//   the front end takes a byte every cycle while the entry queue has room;
//   the lexer state updates on every accepted byte, so back-to-back bytes are fine.
//   an accepted byte is written into the entry queue, then loaded into the
//   output register, which raises m_tvalid for its first result.
//   throughput: one byte per cycle, limited by the output side at one result
//   per cycle while m_tready is high; a two-result byte occupies it for both.
//   when the receiver stalls, results wait in the output register and up to
//   QUEUE_DEPTH entries collect in the queue before s_tready falls.
//   reset: lexer idle, line count 1, queue and output register empty.
module text_value_tokenizer #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,    // char_in[7:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata,    // char_value[15:0], frac_flag, error_code[1:0],
                                    // line_number[31:0], zero fill
    output logic [4:0]  m_tuser,    // event_res, token_type[3:0]
    output logic        m_tlast
);

    tvt_pkg::entry_t push_entry, pop_entry;
    logic            push, pop, full, nonempty;

    tvt_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .q_full   (full),
        .q_push   (push),
        .q_entry  (push_entry)
    );

    tvt_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .pop_entry  (pop_entry),
        .full       (full),
        .nonempty   (nonempty)
    );

    tvt_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .q_nonempty (nonempty),
        .q_entry    (pop_entry),
        .q_pop      (pop),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .m_tlast    (m_tlast)
    );

endmodule
